// File: rtl/rkpp_pkg.sv
// ----------------------------------------------------------------------------
// rkpp_pkg
// shared types, command codes and fixed-point helpers of the runge-kutta
// predator-prey stepper
// ----------------------------------------------------------------------------
package rkpp_pkg;

    localparam int MAX_STAGES = 4;

    // configuration register indexes
    localparam logic [2:0] REG_STAGE_COUNT = 3'd0;
    localparam logic [2:0] REG_ROW_ONE     = 3'd1;
    localparam logic [2:0] REG_ROW_TWO     = 3'd2;
    localparam logic [2:0] REG_ROW_THREE   = 3'd3;
    localparam logic [2:0] REG_WEIGHTS     = 3'd4;
    localparam logic [2:0] REG_MODEL       = 3'd5;
    localparam logic [2:0] REG_STEP_SIZE   = 3'd6;

    localparam logic [2:0]  STAGE_COUNT_RESET = 3'd1;
    localparam logic [63:0] MODEL_RESET       = 64'h1800_1000_2000_1000;
    localparam logic [23:0] STEP_SIZE_RESET   = 24'd16777;

    // datapath operations
    localparam logic [3:0] OP_NOP  = 4'd0;
    localparam logic [3:0] OP_LOAD = 4'd1;
    localparam logic [3:0] OP_CLR  = 4'd2;
    localparam logic [3:0] OP_ACC  = 4'd3;
    localparam logic [3:0] OP_HI   = 4'd4;
    localparam logic [3:0] OP_LO   = 4'd5;
    localparam logic [3:0] OP_T0   = 4'd6;
    localparam logic [3:0] OP_F0   = 4'd7;
    localparam logic [3:0] OP_T1   = 4'd8;
    localparam logic [3:0] OP_F1   = 4'd9;
    localparam logic [3:0] OP_INC  = 4'd10;

    typedef struct packed {
        logic [3:0] op;
        logic       sp;       // 0 prey, 1 predator
        logic [1:0] j;
        logic [1:0] stage;
        logic       last;     // final weighted update
        logic       capture;
    } rkpp_cmd_t;

    typedef struct packed {
        logic [2:0] stage_count;
    } rkpp_status_t;

    typedef struct packed {
        logic              hit;
        logic signed [31:0] value;
    } rkpp_clip_t;

    function automatic rkpp_clip_t rkpp_clip32(input logic signed [65:0] v);
        rkpp_clip_t r;
        if (v > 66'sd2147483647)
        begin
            r.hit   = 1'b1;
            r.value = 32'sh7fff_ffff;
        end
        else if (v < -66'sd2147483648)
        begin
            r.hit   = 1'b1;
            r.value = 32'sh8000_0000;
        end
        else
        begin
            r.hit   = 1'b0;
            r.value = v[31:0];
        end
        return r;
    endfunction

endpackage

// File: rtl/rkpp_in_if.sv
// ----------------------------------------------------------------------------
// rkpp_in_if
// input channel: command word with the load values
// ----------------------------------------------------------------------------
interface rkpp_in_if;
    logic               valid;
    logic               ready;
    logic               cmd;
    logic signed [31:0] load_prey;
    logic signed [31:0] load_predator;

    modport source (output valid, output cmd, output load_prey, output load_predator,
                    input ready);
    modport sink   (input valid, input cmd, input load_prey, input load_predator,
                    output ready);
endinterface

// File: rtl/rkpp_out_if.sv
// ----------------------------------------------------------------------------
// rkpp_out_if
// output channel: state word after each item
// ----------------------------------------------------------------------------
interface rkpp_out_if;
    logic               valid;
    logic               ready;
    logic [31:0]        step_number;
    logic signed [31:0] prey_value;
    logic signed [31:0] predator_value;
    logic               saturated;

    modport source (output valid, output step_number, output prey_value,
                    output predator_value, output saturated, input ready);
    modport sink   (input valid, input step_number, input prey_value,
                    input predator_value, input saturated, output ready);
endinterface

// File: rtl/rk_predator_prey_step.sv
// ----------------------------------------------------------------------------
// rk_predator_prey_step
// explicit runge-kutta stepper for a two-species lotka-volterra system
// ----------------------------------------------------------------------------
// One item at a time. Every multiply goes through the one shared 33x33
// multiplier, is issued and then written back, and there are 2j + 8
// multiplies for stage j plus 2n + 4 for the final update of a step word
// with n stages in use. A new word is taken as soon as the previous result
// sits in the output register, even if it is not yet taken downstream.
// State is Q8.24, coefficients Q4.12, step size Q0.24.
module rk_predator_prey_step
    import rkpp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    rkpp_in_if.sink     in_ch,
    rkpp_out_if.source  out_ch,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    rkpp_cmd_t    cmd;
    rkpp_status_t status;

    rkpp_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_cmd    (in_ch.cmd),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .status    (status),
        .cmd       (cmd)
    );

    rkpp_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .cmd            (cmd),
        .load_prey      (in_ch.load_prey),
        .load_predator  (in_ch.load_predator),
        .status         (status),
        .step_number    (out_ch.step_number),
        .prey_value     (out_ch.prey_value),
        .predator_value (out_ch.predator_value),
        .saturated      (out_ch.saturated)
    );

endmodule

// File: rtl/rkpp_datapath.sv
// ----------------------------------------------------------------------------
// rkpp_datapath
// configuration registers, state, stage slopes and one shared multiplier
// ----------------------------------------------------------------------------
module rkpp_datapath
    import rkpp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [63:0]         cfg_data,
    input  rkpp_cmd_t           cmd,
    input  logic signed [31:0]  load_prey,
    input  logic signed [31:0]  load_predator,
    output rkpp_status_t        status,
    output logic [31:0]         step_number,
    output logic signed [31:0]  prey_value,
    output logic signed [31:0]  predator_value,
    output logic                saturated
);

    logic [2:0]  stage_count_reg;
    logic [63:0] row_one_reg, row_two_reg, row_three_reg, weights_reg, model_reg;
    logic [23:0] tau_reg;

    logic signed [31:0] prey_reg, pred_reg, x_reg, y_reg, t_reg;
    logic [31:0]        steps_reg;
    logic               sat_reg;
    logic signed [50:0] acc0_reg, acc1_reg;
    logic signed [45:0] hold_reg;
    logic signed [31:0] k0_reg [MAX_STAGES];
    logic signed [31:0] k1_reg [MAX_STAGES];

    logic signed [65:0] prod_reg;
    rkpp_cmd_t          wb_reg;

    logic [31:0]        out_step_reg;
    logic signed [31:0] out_prey_reg, out_pred_reg;
    logic               out_sat_reg;

    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_p;
    logic [63:0]        coef_row;
    logic [15:0]        coef_raw;
    logic signed [50:0] acc_sel;
    logic signed [38:0] s_val;
    logic signed [15:0] alpha, beta, gamma_c, delta;

    logic signed [64:0] adv_sum;
    logic signed [31:0] adv_base;
    rkpp_clip_t         adv_res, t0_res, t1_res, f_res;

    assign alpha   = model_reg[15:0];
    assign beta    = model_reg[31:16];
    assign gamma_c = model_reg[47:32];
    assign delta   = model_reg[63:48];

    assign status.stage_count = stage_count_reg;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_count_reg <= STAGE_COUNT_RESET;
            row_one_reg     <= '0;
            row_two_reg     <= '0;
            row_three_reg   <= '0;
            weights_reg     <= '0;
            model_reg       <= MODEL_RESET;
            tau_reg         <= STEP_SIZE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_STAGE_COUNT: stage_count_reg <= cfg_data[2:0];
                REG_ROW_ONE:     row_one_reg     <= cfg_data;
                REG_ROW_TWO:     row_two_reg     <= cfg_data;
                REG_ROW_THREE:   row_three_reg   <= cfg_data;
                REG_WEIGHTS:     weights_reg     <= cfg_data;
                REG_MODEL:       model_reg       <= cfg_data;
                REG_STEP_SIZE:   tau_reg         <= cfg_data[23:0];
                default:         ;
            endcase
        end
    end

    // operand selection
    always_comb
    begin
        if (cmd.last)
            coef_row = weights_reg;
        else
        begin
            case (cmd.stage)
                2'd1:    coef_row = row_one_reg;
                2'd2:    coef_row = row_two_reg;
                2'd3:    coef_row = row_three_reg;
                default: coef_row = '0;
            endcase
        end
        coef_raw = coef_row[16*cmd.j +: 16];
        acc_sel  = cmd.sp ? acc1_reg : acc0_reg;
        s_val    = acc_sel[50:12];

        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            OP_ACC:
            begin
                mul_a = 33'(signed'(coef_raw));
                mul_b = cmd.sp ? 33'(k1_reg[cmd.j]) : 33'(k0_reg[cmd.j]);
            end
            OP_HI:
            begin
                mul_a = 33'(signed'(s_val[38:19]));
                mul_b = {9'b0, tau_reg};
            end
            OP_LO:
            begin
                mul_a = {14'b0, s_val[18:0]};
                mul_b = {9'b0, tau_reg};
            end
            OP_T0:
            begin
                mul_a = 33'(beta);
                mul_b = 33'(y_reg);
            end
            OP_F0:
            begin
                mul_a = 33'(t_reg);
                mul_b = 33'(x_reg);
            end
            OP_T1:
            begin
                mul_a = 33'(delta);
                mul_b = 33'(x_reg);
            end
            OP_F1:
            begin
                mul_a = 33'(t_reg);
                mul_b = 33'(y_reg);
            end
            default: ;
        endcase
    end

    assign mul_p = mul_a * mul_b;

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_p;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            wb_reg <= '0;
        else
            wb_reg <= cmd;
    end

    // writeback arithmetic on the registered product and command
    always_comb
    begin
        adv_sum  = (65'(hold_reg) <<< 19) + 65'(prod_reg);
        adv_base = wb_reg.sp ? pred_reg : prey_reg;
        adv_res  = rkpp_clip32(66'(adv_base) + 66'(signed'(adv_sum[64:24])));
        t0_res   = rkpp_clip32(66'(signed'({alpha, 12'b0}))
                               - 66'(signed'(prod_reg[47:12])));
        t1_res   = rkpp_clip32(66'(signed'(prod_reg[47:12]))
                               - 66'(signed'({gamma_c, 12'b0})));
        f_res    = rkpp_clip32(66'(signed'(prod_reg[65:24])));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prey_reg  <= '0;
            pred_reg  <= '0;
            steps_reg <= '0;
            sat_reg   <= 1'b0;
        end
        else
        begin
            // immediate operations
            case (cmd.op)
                OP_LOAD:
                begin
                    prey_reg  <= load_prey;
                    pred_reg  <= load_predator;
                    steps_reg <= '0;
                    sat_reg   <= 1'b0;
                end
                OP_CLR:  sat_reg   <= 1'b0;
                OP_INC:  steps_reg <= steps_reg + 32'd1;
                default: ;
            endcase
            if (wb_reg.op == OP_LO && wb_reg.last)
            begin
                if (wb_reg.sp)
                    pred_reg <= adv_res.value;
                else
                    prey_reg <= adv_res.value;
                sat_reg <= sat_reg | adv_res.hit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_CLR)
        begin
            acc0_reg <= '0;
            acc1_reg <= '0;
        end
        case (wb_reg.op)
            OP_ACC:
            begin
                if (wb_reg.sp)
                    acc1_reg <= acc1_reg + prod_reg[50:0];
                else
                    acc0_reg <= acc0_reg + prod_reg[50:0];
            end
            OP_HI: hold_reg <= prod_reg[45:0];
            OP_LO:
            begin
                if (!wb_reg.last)
                begin
                    if (wb_reg.sp)
                        y_reg <= adv_res.value;
                    else
                        x_reg <= adv_res.value;
                end
            end
            OP_T0: t_reg <= t0_res.value;
            OP_T1: t_reg <= t1_res.value;
            OP_F0: k0_reg[wb_reg.stage] <= f_res.value;
            OP_F1: k1_reg[wb_reg.stage] <= f_res.value;
            default: ;
        endcase
    end

    // output word
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            out_step_reg <= steps_reg;
            out_prey_reg <= prey_reg;
            out_pred_reg <= pred_reg;
            out_sat_reg  <= sat_reg;
        end
    end

    assign step_number    = out_step_reg;
    assign prey_value     = out_prey_reg;
    assign predator_value = out_pred_reg;
    assign saturated      = out_sat_reg;

endmodule

// File: rtl/rkpp_controller.sv
// ----------------------------------------------------------------------------
// rkpp_controller
// sequences stage sums, stage arguments, slopes and the final update
// ----------------------------------------------------------------------------
module rkpp_controller
    import rkpp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    input  logic         in_cmd,
    output logic         in_ready,
    output logic         out_valid,
    input  logic         out_ready,
    input  rkpp_status_t status,
    output rkpp_cmd_t    cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CLR   = 3'd1;
    localparam logic [2:0] S_ACC   = 3'd2;
    localparam logic [2:0] S_HI    = 3'd3;
    localparam logic [2:0] S_LO    = 3'd4;
    localparam logic [2:0] S_SLOPE = 3'd5;
    localparam logic [2:0] S_INC   = 3'd6;
    localparam logic [2:0] S_OUT   = 3'd7;

    logic [2:0] state_reg, state_next;
    logic       wait_reg, wait_next;
    logic [2:0] stage_reg, stage_next;
    logic [2:0] n_reg, n_next;
    logic [1:0] j_reg, j_next;
    logic       sp_reg, sp_next;
    logic [1:0] sub_reg, sub_next;
    logic       out_valid_reg, out_valid_next;
    logic       last;
    logic [2:0] lim;
    logic [2:0] n_clamped;

    assign last     = (stage_reg == n_reg);
    assign lim      = last ? n_reg : stage_reg;
    assign in_ready = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        if (status.stage_count == 3'd0)
            n_clamped = 3'd1;
        else if (status.stage_count > 3'(MAX_STAGES))
            n_clamped = 3'(MAX_STAGES);
        else
            n_clamped = status.stage_count;
    end

    always_comb
    begin
        state_next  = state_reg;
        wait_next   = wait_reg;
        stage_next  = stage_reg;
        n_next      = n_reg;
        j_next      = j_reg;
        sp_next     = sp_reg;
        sub_next    = sub_reg;
        cmd         = '0;
        cmd.op      = OP_NOP;
        cmd.sp      = sp_reg;
        cmd.j       = j_reg;
        cmd.stage   = stage_reg[1:0];
        cmd.last    = last;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_cmd)
                    begin
                        cmd.op     = OP_LOAD;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        n_next     = n_clamped;
                        stage_next = 3'd0;
                        state_next = S_CLR;
                    end
                end
            end
            S_CLR:
            begin
                cmd.op    = OP_CLR;
                j_next    = 2'd0;
                sp_next   = 1'b0;
                wait_next = 1'b0;
                state_next = (lim == 3'd0) ? S_HI : S_ACC;
            end
            S_ACC:
            begin
                if (!wait_reg)
                begin
                    cmd.op    = OP_ACC;
                    wait_next = 1'b1;
                end
                else
                begin
                    wait_next = 1'b0;
                    if (sp_reg)
                    begin
                        sp_next = 1'b0;
                        if ({1'b0, j_reg} == lim - 3'd1)
                            state_next = S_HI;
                        else
                            j_next = j_reg + 2'd1;
                    end
                    else
                        sp_next = 1'b1;
                end
            end
            S_HI:
            begin
                if (!wait_reg)
                begin
                    cmd.op    = OP_HI;
                    wait_next = 1'b1;
                end
                else
                begin
                    wait_next  = 1'b0;
                    state_next = S_LO;
                end
            end
            S_LO:
            begin
                if (!wait_reg)
                begin
                    cmd.op    = OP_LO;
                    wait_next = 1'b1;
                end
                else
                begin
                    wait_next = 1'b0;
                    if (!sp_reg)
                    begin
                        sp_next    = 1'b1;
                        state_next = S_HI;
                    end
                    else
                    begin
                        sp_next    = 1'b0;
                        sub_next   = 2'd0;
                        state_next = last ? S_INC : S_SLOPE;
                    end
                end
            end
            S_SLOPE:
            begin
                if (!wait_reg)
                begin
                    case (sub_reg)
                        2'd0:    cmd.op = OP_T0;
                        2'd1:    cmd.op = OP_F0;
                        2'd2:    cmd.op = OP_T1;
                        default: cmd.op = OP_F1;
                    endcase
                    wait_next = 1'b1;
                end
                else
                begin
                    wait_next = 1'b0;
                    if (sub_reg == 2'd3)
                    begin
                        stage_next = stage_reg + 3'd1;
                        state_next = S_CLR;
                    end
                    else
                        sub_next = sub_reg + 2'd1;
                end
            end
            S_INC:
            begin
                cmd.op     = OP_INC;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        if (cmd.capture)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            wait_reg      <= 1'b0;
            stage_reg     <= 3'd0;
            n_reg         <= 3'd1;
            j_reg         <= 2'd0;
            sp_reg        <= 1'b0;
            sub_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wait_reg      <= wait_next;
            stage_reg     <= stage_next;
            n_reg         <= n_next;
            j_reg         <= j_next;
            sp_reg        <= sp_next;
            sub_reg       <= sub_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// File: rtl/rkpp_checker.sv
// ----------------------------------------------------------------------------
// rkpp_checker
// port-level checks of the stepper, bound to the top level
// ----------------------------------------------------------------------------
module rkpp_checker
(
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready
);

    // a held result word stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result word dropped before it was taken");

    // one word at a time: busy right after an accept
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken again while a word is in progress");

    // ready only drops because a word was taken
    a_ready_fall: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(in_ready) |-> $past(in_valid))
        else $error("input ready fell without an accepted word");

    // a result appears only after some accepted word
    a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !in_ready || $past(!in_ready))
        else $error("result word without a word in progress");

endmodule

bind rk_predator_prey_step rkpp_checker u_rkpp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready)
);

// File: tb/rkpp_tb_pkg.sv
// ----------------------------------------------------------------------------
// rkpp_tb_pkg
// fixed-point predictor of the runge-kutta predator-prey stepper
// ----------------------------------------------------------------------------
package rkpp_tb_pkg;
    import rkpp_pkg::*;

    typedef struct packed {
        logic [31:0]        step_number;
        logic signed [31:0] prey_value;
        logic signed [31:0] predator_value;
        logic               saturated;
    } lv_word_t;

    typedef struct {
        logic [2:0]  stage_count;
        logic [63:0] rows [4];
        logic [63:0] weights;
        logic [63:0] model;
        logic [23:0] tau;
    } lv_setup_t;

    // arithmetic shift on a signed value floors
    function automatic longint sat32(input longint v, inout bit hit);
        if (v > 64'sd2147483647)
        begin
            hit = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648)
        begin
            hit = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic longint q412(input logic [63:0] r, input int slot);
        logic signed [15:0] c;
        c = r[16*slot +: 16];
        return longint'(c);
    endfunction

    function automatic longint nudge(input longint base, input longint acc,
                                     input logic [23:0] tau, inout bit hit);
        longint s;
        longint d;
        s = acc >>> 12;
        d = (s * longint'({40'd0, tau})) >>> 24;
        return sat32(base + d, hit);
    endfunction

    function automatic void lv_slope(input lv_setup_t cf, input longint x,
                                     input longint y, output longint f0,
                                     output longint f1);
        bit dummy;
        longint t0;
        longint t1;
        dummy = 0;
        t0 = sat32(q412(cf.model, 0) * 4096 - ((q412(cf.model, 1) * y) >>> 12), dummy);
        t1 = sat32(((q412(cf.model, 3) * x) >>> 12) - q412(cf.model, 2) * 4096, dummy);
        f0 = sat32((t0 * x) >>> 24, dummy);
        f1 = sat32((t1 * y) >>> 24, dummy);
    endfunction

    function automatic lv_word_t rk_advance(input lv_setup_t cf, inout longint prey,
                                            inout longint pred, inout logic [31:0] steps);
        lv_word_t w;
        longint k0 [4];
        longint k1 [4];
        longint a0;
        longint a1;
        longint s0;
        longint s1;
        longint x;
        longint y;
        bit hit;
        bit dummy;
        int n;
        hit = 0;
        dummy = 0;
        a0 = 0;
        a1 = 0;
        n = cf.stage_count;
        if (n < 1) n = 1;
        if (n > MAX_STAGES) n = MAX_STAGES;
        for (int i = 0; i < n; i++)
        begin
            s0 = 0;
            s1 = 0;
            for (int j = 0; j < i; j++)
            begin
                s0 += q412(cf.rows[i], j) * k0[j];
                s1 += q412(cf.rows[i], j) * k1[j];
            end
            x = nudge(prey, s0, cf.tau, dummy);
            y = nudge(pred, s1, cf.tau, dummy);
            lv_slope(cf, x, y, k0[i], k1[i]);
        end
        for (int i = 0; i < n; i++)
        begin
            a0 += q412(cf.weights, i) * k0[i];
            a1 += q412(cf.weights, i) * k1[i];
        end
        prey  = nudge(prey, a0, cf.tau, hit);
        pred  = nudge(pred, a1, cf.tau, hit);
        steps = steps + 32'd1;
        w.step_number    = steps;
        w.prey_value     = prey[31:0];
        w.predator_value = pred[31:0];
        w.saturated      = hit;
        return w;
    endfunction
endpackage

// File: tb/rk_predator_prey_step_test.sv
// ----------------------------------------------------------------------------
// rk_predator_prey_step_test
// drives load and step words through several stage tables, model settings
// and step sizes with random idling on both channels, and checks every
// result word against a fixed-point predictor
// ----------------------------------------------------------------------------
module rk_predator_prey_step_test;
    timeunit 1ns;
    timeprecision 1ps;
    import rkpp_pkg::*;
    import rkpp_tb_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_data;

    rkpp_in_if  in_ch ();
    rkpp_out_if out_ch ();

    rk_predator_prey_step dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch.sink),
        .out_ch    (out_ch.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    lv_setup_t    setup;
    longint       prey_st;
    longint       pred_st;
    logic [31:0]  steps_st;
    lv_word_t     pending_words [$];
    int           errors;
    longint       cycle_count;
    bit           stall_on;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > 64'd2000000)
            begin
                $display("rk_predator_prey_step verification failed");
                $finish;
            end
        end
    end

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        errors++;
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    endtask

    // sink side: random stall bursts while stall_on
    initial
    begin
        int n;
        out_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (stall_on && $urandom_range(0, 3) == 0)
            begin
                n = $urandom_range(1, 16);
                out_ch.ready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge clk);
        end
    end

    initial
    begin
        lv_word_t w;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_ch.valid && out_ch.ready)
            begin
                if (pending_words.size() == 0)
                    report("unexpected word", out_ch.step_number, 32'd0);
                else
                begin
                    w = pending_words.pop_front();
                    if (out_ch.step_number !== w.step_number)
                        report("step_number", out_ch.step_number, w.step_number);
                    if (out_ch.prey_value !== w.prey_value)
                        report("prey_value", out_ch.prey_value, w.prey_value);
                    if (out_ch.predator_value !== w.predator_value)
                        report("predator_value", out_ch.predator_value, w.predator_value);
                    if (out_ch.saturated !== w.saturated)
                        report("saturated", {31'd0, out_ch.saturated}, {31'd0, w.saturated});
                end
            end
        end
    end

    // valid stays up after an accept until the next word, a stall or a drain
    task automatic send_word(input logic cmd, input logic [31:0] lp, input logic [31:0] ld);
        lv_word_t w;
        if (stall_on && $urandom_range(0, 3) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.cmd           <= cmd;
        in_ch.load_prey     <= lp;
        in_ch.load_predator <= ld;
        do @(posedge clk); while (!in_ch.ready);
        if (cmd)
        begin
            prey_st  = longint'($signed(lp));
            pred_st  = longint'($signed(ld));
            steps_st = 0;
            w.step_number    = 0;
            w.prey_value     = lp;
            w.predator_value = ld;
            w.saturated      = 1'b0;
        end
        else
            w = rk_advance(setup, prey_st, pred_st, steps_st);
        pending_words.push_back(w);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    // registers change only with nothing in flight
    task automatic write_reg(input logic [2:0] idx, input logic [63:0] v);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_STAGE_COUNT: setup.stage_count = v[2:0];
            REG_ROW_ONE:     setup.rows[1] = v;
            REG_ROW_TWO:     setup.rows[2] = v;
            REG_ROW_THREE:   setup.rows[3] = v;
            REG_WEIGHTS:     setup.weights = v;
            REG_MODEL:       setup.model = v;
            REG_STEP_SIZE:   setup.tau = v[23:0];
            default: ;
        endcase
    endtask

    // q8.24 population in a modest range, sometimes fully random
    function automatic logic [31:0] rand_pop();
        if ($urandom_range(0, 7) == 0) return $urandom;
        return $urandom_range(0, 32'h0400_0000);
    endfunction

    task automatic run_random(input int n);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 15) == 0)
                send_word(1'b1, rand_pop(), rand_pop());
            else
                send_word(1'b0, $urandom, $urandom);
        end
    endtask

    task automatic test_reset_values();
        send_word(1'b0, 32'h0, 32'h0);
        send_word(1'b1, 32'h0100_0000, 32'h0080_0000);
        repeat (3) send_word(1'b0, 32'hffff_ffff, 32'h0);
        drain();
    endtask

    task automatic test_classic_rk4();
        write_reg(REG_STAGE_COUNT, 64'd4);
        write_reg(REG_ROW_ONE, 64'h0000_0000_0000_0800);
        write_reg(REG_ROW_TWO, 64'h0000_0000_0800_0000);
        write_reg(REG_ROW_THREE, 64'h0000_1000_0000_0000);
        write_reg(REG_WEIGHTS, 64'h02ab_0555_0555_02ab);
        write_reg(REG_STEP_SIZE, 64'd167772);
        send_word(1'b1, 32'h0100_0000, 32'h0100_0000);
        repeat (5) send_word(1'b0, 32'h0, 32'h0);
        drain();
    endtask

    task automatic test_extremes();
        write_reg(REG_STEP_SIZE, 64'hff_ffff);
        write_reg(REG_MODEL, 64'h7fff_8000_7fff_8000);
        write_reg(REG_WEIGHTS, 64'h7fff_7fff_7fff_7fff);
        send_word(1'b1, 32'h7fff_ffff, 32'h8000_0000);
        send_word(1'b0, 32'h0, 32'h0);
        send_word(1'b1, 32'h8000_0000, 32'h7fff_ffff);
        send_word(1'b0, 32'h0, 32'h0);
        write_reg(REG_STAGE_COUNT, 64'd0);
        send_word(1'b0, 32'h0, 32'h0);
        write_reg(REG_STAGE_COUNT, 64'd7);
        send_word(1'b0, 32'h0, 32'h0);
        write_reg(REG_STEP_SIZE, 64'd0);
        send_word(1'b0, 32'h0, 32'h0);
        drain();
    endtask

    task automatic test_random_setups();
        for (int p = 0; p < 14; p++)
        begin
            write_reg(REG_STAGE_COUNT, 64'($urandom_range(0, 7)));
            for (int r = 1; r <= 4; r++)
                write_reg(3'(r), {$urandom, $urandom});
            if ($urandom_range(0, 1))
                write_reg(REG_MODEL, MODEL_RESET);
            else
                write_reg(REG_MODEL, {$urandom, $urandom});
            write_reg(REG_STEP_SIZE, 64'($urandom_range(0, 24'hff_ffff)));
            if (p == 13)
                stall_on = 1'b0;
            run_random(100);
            drain();
        end
    endtask

    initial
    begin
        errors       = 0;
        stall_on     = 1'b1;
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        in_ch.valid  = 1'b0;
        in_ch.cmd    = 1'b0;
        in_ch.load_prey     = '0;
        in_ch.load_predator = '0;
        setup.stage_count = STAGE_COUNT_RESET;
        for (int r = 0; r < 4; r++) setup.rows[r] = '0;
        setup.weights = '0;
        setup.model   = MODEL_RESET;
        setup.tau     = STEP_SIZE_RESET;
        prey_st  = 0;
        pred_st  = 0;
        steps_st = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_values();
        test_classic_rk4();
        test_extremes();
        test_random_setups();
        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("rk_predator_prey_step verification clean");
        else
            $display("rk_predator_prey_step verification failed");
        $finish;
    end
endmodule
